>>> src/cmsc_pkg.sv
package cmsc_pkg;

    localparam int NUM_CORES_DEF  = 4;
    localparam int SLOTS_PER_CORE = 4;
    localparam int MBOX_COUNT     = 16;
    localparam int MBOX_IDX_W     = 4;
    localparam int MAX_CORES      = 4;

    localparam logic [7:0] WINDOW_BASE = 8'h80;
    localparam logic [7:0] CLEAR_BASE  = 8'hC0;
    localparam logic [6:0] SIZE_OK     = 7'd32;
    localparam logic [2:0] CFG_RESET   = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_NOT_ASSIGNED = 3'd2;
    localparam logic [2:0] ST_WRITE_ONLY   = 3'd3;
    localparam logic [2:0] ST_UNMAPPED     = 3'd4;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the access and register its result
    } t_dp_cmd;

endpackage

>>> src/cmsc_ctrl.sv
module cmsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_done,
    output cmsc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state == S_EXEC);
    assign o_done = (r_state == S_DONE);
    assign accept = start && !busy;

    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);

    always_comb begin
        unique case (r_state)
            S_IDLE, S_DONE: n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:         n_state = S_DONE;
            default:        n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result strobe comes in the cycle after execution
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("done without a preceding execute cycle");

    // the execute state always passes straight to the done state
    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("execute state held longer than one cycle");

endmodule

>>> src/cmsc_dpath.sv
module cmsc_dpath #(
    parameter int NUM_CORES = cmsc_pkg::NUM_CORES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmsc_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_wdata,
    input  logic                 i_kind,
    input  logic [7:0]           i_offset,
    input  logic [31:0]          i_write_data,
    input  logic [6:0]           i_access_size,
    output logic [31:0]          o_read_data,
    output logic [2:0]           o_status,
    output logic                 o_irq_kick,
    output logic [1:0]           o_irq_core,
    output logic [3:0]           o_core_pending
);

    localparam logic [2:0] CoreLimit = 3'(NUM_CORES);

    logic [2:0]  r_cores_assigned;
    logic        r_kind;
    logic [7:0]  r_off;
    logic [31:0] r_wdata;
    logic [6:0]  r_size;
    logic [31:0] r_mbox [cmsc_pkg::MBOX_COUNT];

    logic [31:0] r_rdata;
    logic [2:0]  r_status;
    logic        r_kick;
    logic [1:0]  r_core;

    logic [1:0]                     core;
    logic [cmsc_pkg::MBOX_IDX_W-1:0] idx;
    logic [2:0]                     limit;
    logic [2:0]                     n_status;
    logic [31:0]                    n_rdata;
    logic                           n_kick;
    logic                           n_wr_set;
    logic                           n_wr_clr;

    assign core  = r_off[5:4];
    assign idx   = {r_off[5:4], r_off[3:2]};
    assign limit = (r_cores_assigned > CoreLimit) ? CoreLimit : r_cores_assigned;

    // check order: size, core, mapping, write-only window
    always_comb begin
        n_status = cmsc_pkg::ST_OK;
        n_rdata  = '0;
        n_kick   = 1'b0;
        n_wr_set = 1'b0;
        n_wr_clr = 1'b0;
        priority if (r_size != cmsc_pkg::SIZE_OK) begin
            n_status = cmsc_pkg::ST_BAD_SIZE;
        end else if ({1'b0, core} >= limit) begin
            n_status = cmsc_pkg::ST_NOT_ASSIGNED;
        end else if (r_off < cmsc_pkg::WINDOW_BASE || r_off[1:0] != 2'b00) begin
            n_status = cmsc_pkg::ST_UNMAPPED;
        end else if (r_off < cmsc_pkg::CLEAR_BASE) begin
            if (r_kind == cmsc_pkg::KIND_WRITE) begin
                n_wr_set = 1'b1;
                n_kick   = 1'b1;
            end else begin
                n_status = cmsc_pkg::ST_WRITE_ONLY;
            end
        end else begin
            if (r_kind == cmsc_pkg::KIND_WRITE) begin
                n_wr_clr = 1'b1;
                n_kick   = 1'b1;
            end else begin
                n_rdata = r_mbox[idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores_assigned <= cmsc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cores_assigned <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_off   <= i_offset;
            r_wdata <= i_write_data;
            r_size  <= i_access_size;
        end
        if (i_cmd.exec) begin
            r_rdata  <= n_rdata;
            r_status <= n_status;
            r_kick   <= n_kick;
            r_core   <= core;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cmsc_pkg::MBOX_COUNT; i++) begin
                r_mbox[i[cmsc_pkg::MBOX_IDX_W-1:0]] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (n_wr_set) begin
                r_mbox[idx] <= r_mbox[idx] | r_wdata;
            end else if (n_wr_clr) begin
                r_mbox[idx] <= r_mbox[idx] & ~r_wdata;
            end
        end
    end

    // pending per core, reflects the mailboxes after the last executed access
    always_comb begin
        o_core_pending = '0;
        for (int c = 0; c < cmsc_pkg::MAX_CORES; c++) begin
            for (int s = 0; s < cmsc_pkg::SLOTS_PER_CORE; s++) begin
                if (r_mbox[{c[1:0], s[1:0]}] != '0) begin
                    o_core_pending[c[1:0]] = 1'b1;
                end
            end
        end
    end

    assign o_read_data = r_rdata;
    assign o_status    = r_status;
    assign o_irq_kick  = r_kick;
    assign o_irq_core  = r_core;

    // a failed access never touches a mailbox
    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status != cmsc_pkg::ST_OK) |-> !(n_wr_set || n_wr_clr))
        else $error("mailbox written by a failed access");

    // kick is raised exactly for executed writes that pass every check
    a_kick_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_kick == $past(n_wr_set || n_wr_clr)))
        else $error("irq kick does not match the executed write");

endmodule

>>> src/core_mailbox_set_clear.sv
// Accepting an item (start high, busy low) enters the execute state, then the done
// state, where o_done strobes. busy is high only in the execute state, and a new
// item may be accepted in the same cycle that o_done strobes.
// Each result is valid only while o_done is high; the receiver cannot stall it.
// Reset (i_rst_n low, synchronous): clear all sixteen mailboxes, set cores_assigned
// to 4, return the controller to idle.
module core_mailbox_set_clear #(
    parameter int NUM_CORES = cmsc_pkg::NUM_CORES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access request
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [7:0]  i_offset,
    input  logic [31:0] i_write_data,
    input  logic [6:0]  i_access_size,
    // configuration: cores_assigned
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // result item, one strobe per access
    output logic        o_done,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_status,
    output logic        o_irq_kick,
    output logic [1:0]  o_irq_core,
    output logic [3:0]  o_core_pending
);

    cmsc_pkg::t_dp_cmd cmd;

    // Controller: accept an item, run it in the execute state, strobe the result.
    cmsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Datapath: hold the item, decode the offset, update the addressed
    // mailbox and register the result fields. The pending mask is taken
    // straight from the mailbox registers, so it already includes the
    // effect of the access being reported.
    cmsc_dpath #(
        .NUM_CORES (NUM_CORES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_offset       (i_offset),
        .i_write_data   (i_write_data),
        .i_access_size  (i_access_size),
        .o_read_data    (o_read_data),
        .o_status       (o_status),
        .o_irq_kick     (o_irq_kick),
        .o_irq_core     (o_irq_core),
        .o_core_pending (o_core_pending)
    );

    // an accepted item always produces its result through the execute and done states
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted item produced no result");

    // read data only on a successful read
    a_rdata_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_read_data != '0) |-> (o_status == cmsc_pkg::ST_OK && !o_irq_kick))
        else $error("read data reported on a failed access or write");

endmodule
